[rtl/ilir_pkg.sv]
`default_nettype none
package ilir_pkg;

	// Fixed field widths of the request and response transactions
	localparam int KindW   = 3;
	localparam int IndexW  = 7;
	localparam int ValueW  = 32;
	localparam int CountW  = 7;
	localparam int StatusW = 2;

	// Defaults for the top-level parameters
	localparam int CapacityDef  = 64;
	localparam int DataWidthDef = 32;

	// Request kinds
	localparam logic [KindW-1:0] KIND_APPEND = 3'd0;
	localparam logic [KindW-1:0] KIND_INSERT = 3'd1;
	localparam logic [KindW-1:0] KIND_GET    = 3'd2;
	localparam logic [KindW-1:0] KIND_FIND   = 3'd3;
	localparam logic [KindW-1:0] KIND_REMOVE = 3'd4;

	// Response status codes
	localparam logic [StatusW-1:0] ST_OK    = 2'd0;
	localparam logic [StatusW-1:0] ST_RANGE = 2'd1;
	localparam logic [StatusW-1:0] ST_FULL  = 2'd2;

	// Broadcast shift command for the row of cells
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctl_t;

endpackage
`default_nettype wire

[rtl/ilir_ifs.sv]
`default_nettype none
interface ilir_req_if;
	logic                                  valid;
	logic                                  ready;
	logic        [ilir_pkg::KindW-1:0]     kind;
	logic        [ilir_pkg::IndexW-1:0]    index;
	logic signed [ilir_pkg::ValueW-1:0]    value;

	modport source (output valid, kind, index, value, input ready);
	modport sink (input valid, kind, index, value, output ready);
endinterface

interface ilir_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [ilir_pkg::ValueW-1:0]    read_value;
	logic                                  found;
	logic        [ilir_pkg::CountW-1:0]    count;
	logic        [ilir_pkg::StatusW-1:0]   status;

	modport source (output valid, read_value, found, count, status, input ready);
	modport sink (input valid, read_value, found, count, status, output ready);
endinterface
`default_nettype wire

[rtl/ilir_cell.sv]
`default_nettype none
module ilir_cell #(
	parameter int DATA_WIDTH = ilir_pkg::DataWidthDef,
	parameter int POS_W      = 7,
	parameter int IDX        = 0
) (
	input  wire                    clk,
	input  wire                    capture,
	input  wire ilir_pkg::cell_ctl_t ctl,
	input  wire  [POS_W-1:0]       pos,
	input  wire  [POS_W-1:0]       count,
	input  wire  [DATA_WIDTH-1:0]  value,
	input  wire  [DATA_WIDTH-1:0]  left_data,
	input  wire  [DATA_WIDTH-1:0]  right_data,
	output logic [DATA_WIDTH-1:0]  data_q,
	output logic [DATA_WIDTH-1:0]  sel_s1,
	output logic                   hit_s1
);

	localparam logic [POS_W-1:0] MyIdx = POS_W'(IDX);

	logic above_pos;
	logic at_pos;

	assign above_pos = MyIdx > pos;
	assign at_pos    = MyIdx == pos;

	// Shift up on insert, shift down on remove
	always_ff @(posedge clk) begin
		if (capture && ctl.ins) begin
			if (above_pos) begin
				data_q <= left_data;
			end else if (at_pos) begin
				data_q <= value;
			end
		end else if (capture && ctl.rem) begin
			if (above_pos || at_pos) begin
				data_q <= right_data;
			end
		end
	end

	// Snapshot lookup results before the entry changes
	always_ff @(posedge clk) begin
		if (capture) begin
			sel_s1 <= at_pos ? data_q : '0;
			hit_s1 <= (data_q == value) && (MyIdx < count);
		end
	end

endmodule
`default_nettype wire

[rtl/ilir_reduce.sv]
`default_nettype none
module ilir_reduce #(
	parameter int DATA_WIDTH = ilir_pkg::DataWidthDef,
	parameter int CAPACITY   = ilir_pkg::CapacityDef
) (
	input  wire  [DATA_WIDTH-1:0] sel [CAPACITY],
	input  wire  [CAPACITY-1:0]   hit,
	output logic [DATA_WIDTH-1:0] sel_or,
	output logic                  hit_any
);

	always_comb begin
		sel_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			sel_or = sel_or | sel[i];
		end
	end

	assign hit_any = |hit;

endmodule
`default_nettype wire

[rtl/indexed_list_insert_remove.sv]
// An accepted request is registered in the lookup stage, then in the output register that drives rsp.
// The single lookup stage between the cell row and the output register takes a new request
//   only once its previous one moved on.
// A request may be accepted while the previous response still waits to be taken.
// Reset: arst_n clears the entry count and all valid flags; cell contents stay undefined.
`default_nettype none
module indexed_list_insert_remove #(
	parameter int CAPACITY   = ilir_pkg::CapacityDef,
	parameter int DATA_WIDTH = ilir_pkg::DataWidthDef
) (
	input  wire          clk,
	input  wire          arst_n,
	ilir_req_if.sink     req,
	ilir_rsp_if.source   rsp
);

	// Count holds 0..CAPACITY; positions compare at the wider of count and index
	localparam int CntW = $clog2(CAPACITY + 1);
	localparam int PosW = (CntW > ilir_pkg::IndexW) ? CntW : ilir_pkg::IndexW;

	logic [CntW-1:0] count_q;
	logic [CntW-1:0] count_next;
	logic [PosW-1:0] cnt_ext;
	logic [PosW-1:0] idx_ext;
	logic [PosW-1:0] pos;
	logic            full;
	logic            accept;

	ilir_pkg::cell_ctl_t          ctl;
	logic [ilir_pkg::StatusW-1:0] status;
	logic signed [63:0]           value_ext;
	logic [DATA_WIDTH-1:0]        value_d;

	// Lookup stage
	logic                         s1_valid_q;
	logic [ilir_pkg::KindW-1:0]   kind_s1;
	logic [ilir_pkg::StatusW-1:0] status_s1;
	logic [ilir_pkg::CountW-1:0]  count_s1;
	logic                         advance;

	// Cell row
	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_sel [CAPACITY];
	logic [CAPACITY-1:0]   cell_hit;
	logic [DATA_WIDTH-1:0] sel_or;
	logic                  hit_any;

	// Output register
	logic                          out_valid_q;
	logic signed [ilir_pkg::ValueW-1:0] read_value_q;
	logic                          found_q;
	logic [ilir_pkg::CountW-1:0]   count_out_q;
	logic [ilir_pkg::StatusW-1:0]  status_q;

	assign accept  = req.valid && req.ready;
	assign advance = s1_valid_q && (!out_valid_q || rsp.ready);

	// Take a new request as soon as the lookup stage is empty
	assign req.ready = !s1_valid_q;

	assign cnt_ext = PosW'(count_q);
	assign idx_ext = PosW'(req.index);
	assign full    = count_q == CntW'(CAPACITY);

	// Sign-extend the 32-bit value, then keep DATA_WIDTH bits
	assign value_ext = 64'(req.value);
	assign value_d   = value_ext[DATA_WIDTH-1:0];

	// Decode the request into a shift command, a position and a status
	always_comb begin
		ctl        = '0;
		pos        = idx_ext;
		status     = ilir_pkg::ST_OK;
		count_next = count_q;
		unique case (req.kind)
			ilir_pkg::KIND_APPEND: begin
				pos = cnt_ext;
				if (full) begin
					status = ilir_pkg::ST_FULL;
				end else begin
					ctl.ins    = 1'b1;
					count_next = count_q + CntW'(1);
				end
			end
			ilir_pkg::KIND_INSERT: begin
				if (idx_ext > cnt_ext) begin
					status = ilir_pkg::ST_RANGE;
				end else if (full) begin
					status = ilir_pkg::ST_FULL;
				end else begin
					ctl.ins    = 1'b1;
					count_next = count_q + CntW'(1);
				end
			end
			ilir_pkg::KIND_GET: begin
				if (idx_ext >= cnt_ext) begin
					status = ilir_pkg::ST_RANGE;
				end
			end
			ilir_pkg::KIND_REMOVE: begin
				if (idx_ext >= cnt_ext) begin
					status = ilir_pkg::ST_RANGE;
				end else begin
					ctl.rem    = 1'b1;
					count_next = count_q - CntW'(1);
				end
			end
			default: begin
				// find and unused kinds leave the list alone
			end
		endcase
	end

	// Load the updated count on every accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

	// Row of cells: each holds one entry and trades with its neighbors
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = value_d;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		ilir_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.POS_W      (PosW),
			.IDX        (i)
		) u_cell (
			.clk        (clk),
			.capture    (accept),
			.ctl        (accept ? ctl : '0),
			.pos        (pos),
			.count      (cnt_ext),
			.value      (value_d),
			.left_data  (left_d),
			.right_data (right_d),
			.data_q     (cell_data[i]),
			.sel_s1     (cell_sel[i]),
			.hit_s1     (cell_hit[i])
		);
	end

	// Lookup stage control: hold until the output register frees up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= req.kind;
			status_s1 <= status;
			count_s1  <= ilir_pkg::CountW'(count_next);
		end
	end

	ilir_reduce #(
		.DATA_WIDTH (DATA_WIDTH),
		.CAPACITY   (CAPACITY)
	) u_reduce (
		.sel     (cell_sel),
		.hit     (cell_hit),
		.sel_or  (sel_or),
		.hit_any (hit_any)
	);

	// Output register: valid drops when the response transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Gate read data to successful gets and the hit flag to finds
	always_ff @(posedge clk) begin
		if (advance) begin
			read_value_q <= (kind_s1 == ilir_pkg::KIND_GET && status_s1 == ilir_pkg::ST_OK)
				? ilir_pkg::ValueW'(sel_or) : '0;
			found_q      <= (kind_s1 == ilir_pkg::KIND_FIND) && hit_any;
			count_out_q  <= count_s1;
			status_q     <= status_s1;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = read_value_q;
	assign rsp.found      = found_q;
	assign rsp.count      = count_out_q;
	assign rsp.status     = status_q;

endmodule
`default_nettype wire

[rtl/ilir_check.sv]
`default_nettype none
module ilir_check #(
	parameter int CAPACITY = ilir_pkg::CapacityDef
) (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               req_valid,
	input wire                               req_ready,
	input wire                               rsp_valid,
	input wire                               rsp_ready,
	input wire [ilir_pkg::ValueW-1:0]        rsp_read_value,
	input wire                               rsp_found,
	input wire [ilir_pkg::CountW-1:0]        rsp_count,
	input wire [ilir_pkg::StatusW-1:0]       rsp_status
);

	localparam bit SmallCap = CAPACITY < (1 << ilir_pkg::CountW);
	localparam logic [ilir_pkg::CountW-1:0] CapLow = ilir_pkg::CountW'(CAPACITY);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before it was taken");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ilir_pkg::ST_FULL |-> !SmallCap || rsp_count == CapLow)
		else $error("full status with a count below capacity");

	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ilir_pkg::ST_OK |-> rsp_read_value == '0 && !rsp_found)
		else $error("error response carries data");

	a_rsp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("response without a request two cycles earlier");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !SmallCap || rsp_count <= CapLow)
		else $error("count exceeds capacity");

endmodule

bind indexed_list_insert_remove ilir_check #(
	.CAPACITY (CAPACITY)
) u_ilir_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_read_value (rsp.read_value),
	.rsp_found      (rsp.found),
	.rsp_count      (rsp.count),
	.rsp_status     (rsp.status)
);
`default_nettype wire

[tb/indexed_list_insert_remove_test.sv]
`default_nettype none
module indexed_list_insert_remove_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ilir_pkg::*;

	localparam int CAPACITY     = CapacityDef;
	localparam int RANDOM_ITEMS = 1680;
	localparam int IDLE_LIMIT   = 4000;  // cycles without any transaction before giving up
	localparam int DRAIN_CYCLES = 8;     // extra wait after the last expected response, for stray responses
	localparam int REPORT_MAX   = 10;

	// Kinds 5..7 carry no operation; the block must answer with count only.
	localparam logic [KindW-1:0] KIND_RSVD_FIRST = 3'd5;
	localparam logic [KindW-1:0] KIND_RSVD_LAST  = 3'd7;

	typedef struct packed {
		logic        [KindW-1:0]  kind;
		logic        [IndexW-1:0] index;
		logic signed [ValueW-1:0] value;
	} list_req_t;

	typedef struct packed {
		logic signed [ValueW-1:0]  read_value;
		logic                      found;
		logic        [CountW-1:0]  count;
		logic        [StatusW-1:0] status;
	} list_rsp_t;

	// Stimulus mixes: grow toward full, drain toward empty, or hover.
	typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED} mix_t;
	// Response-side back-pressure patterns.
	typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_SPARSE, RDY_PERIODIC} rdy_mode_t;

	logic clk;
	logic arst_n;

	ilir_req_if req ();
	ilir_rsp_if rsp ();

	indexed_list_insert_remove #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(DataWidthDef)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	// Request transactions waiting to be driven, in order.
	list_req_t pending_q[$];
	// Responses predicted for accepted requests, oldest first.
	list_rsp_t rsp_expect_q[$];
	// Predicted list contents, index 0 at the front.
	logic signed [ValueW-1:0] list_q[$];

	// Generator-side bookkeeping: entry count as the stimulus will leave it,
	// and recently stored values so that find hits often.
	int                       gen_count;
	logic signed [ValueW-1:0] recent_q[$];

	int  total_items;
	int  accepted_items;
	int  error_cnt;
	int  idle_cycles;
	bit  req_fired;

	// Driver and receiver pacing state.
	int        burst_left;
	int        gap_left;
	rdy_mode_t rdy_mode;
	int        rdy_left;
	int unsigned rdy_phase;

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction: apply one request to the shadow list, return the response.
	// ------------------------------------------------------------------
	function automatic list_rsp_t apply_request(list_req_t r);
		list_rsp_t o;
		int        n;
		int        idx;
		o   = '0;
		n   = list_q.size();
		idx = int'(r.index);
		case (r.kind)
			KIND_APPEND: begin
				if (n >= CAPACITY)
					o.status = ST_FULL;
				else
					list_q.push_back(r.value);
			end
			KIND_INSERT: begin
				// Past the count is a range error even when full.
				if (idx > n)
					o.status = ST_RANGE;
				else if (n >= CAPACITY)
					o.status = ST_FULL;
				else
					list_q.insert(idx, r.value);
			end
			KIND_GET: begin
				if (idx >= n)
					o.status = ST_RANGE;
				else
					o.read_value = list_q[idx];
			end
			KIND_FIND: begin
				foreach (list_q[i])
					if (list_q[i] == r.value)
						o.found = 1'b1;
			end
			KIND_REMOVE: begin
				if (idx >= n)
					o.status = ST_RANGE;
				else
					list_q.delete(idx);
			end
			default: ;
		endcase
		o.count = CountW'(list_q.size());
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus construction
	// ------------------------------------------------------------------
	function automatic void queue_request(logic [KindW-1:0] k, int idx,
			logic signed [ValueW-1:0] v);
		list_req_t r;
		r.kind  = k;
		r.index = IndexW'(idx);
		r.value = v;
		pending_q.push_back(r);
		case (k)
			KIND_APPEND: if (gen_count < CAPACITY) gen_count++;
			KIND_INSERT: if (idx <= gen_count && gen_count < CAPACITY) gen_count++;
			KIND_REMOVE: if (idx < gen_count) gen_count--;
			default: ;
		endcase
		if (k == KIND_APPEND || k == KIND_INSERT) begin
			recent_q.push_back(v);
			if (recent_q.size() > 24)
				void'(recent_q.pop_front());
		end
	endfunction

	function automatic logic signed [ValueW-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 30 && recent_q.size() > 0)
			return recent_q[$urandom_range(0, recent_q.size() - 1)];
		if (roll < 40) begin
			case ($urandom_range(0, 4))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return 32'sh0;
				3: return -32'sd1;
				default: return 32'sh0001_0000;
			endcase
		end
		return $urandom;
	endfunction

	// Mostly legal positions, with the boundary at the count and the odd wild index.
	function automatic int pick_index(logic [KindW-1:0] k);
		int roll;
		int top;
		roll = $urandom_range(0, 9);
		top  = (k == KIND_INSERT || gen_count == 0) ? gen_count : gen_count - 1;
		if (roll < 6)
			return $urandom_range(0, top);
		if (roll < 8)
			return ($urandom_range(0, 1) == 0) ? gen_count : top;
		return $urandom_range(0, (1 << IndexW) - 1);
	endfunction

	function automatic logic [KindW-1:0] pick_kind(mix_t mix);
		int roll;
		roll = $urandom_range(0, 99);
		case (mix)
			MIX_GROW: begin
				if (roll < 35) return KIND_APPEND;
				if (roll < 70) return KIND_INSERT;
				if (roll < 80) return KIND_GET;
				if (roll < 90) return KIND_FIND;
				if (roll < 96) return KIND_REMOVE;
			end
			MIX_SHRINK: begin
				if (roll < 55) return KIND_REMOVE;
				if (roll < 63) return KIND_APPEND;
				if (roll < 71) return KIND_INSERT;
				if (roll < 84) return KIND_GET;
				if (roll < 96) return KIND_FIND;
			end
			default: begin
				if (roll < 19) return KIND_APPEND;
				if (roll < 38) return KIND_INSERT;
				if (roll < 57) return KIND_GET;
				if (roll < 76) return KIND_FIND;
				if (roll < 96) return KIND_REMOVE;
			end
		endcase
		return KindW'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST));
	endfunction

	// ------------------------------------------------------------------
	// Driver: present request transactions at the falling edge, in bursts
	// separated by random gaps. Hold the payload until it is taken.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		list_req_t r;
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (!req.valid || req_fired) begin
			if (gap_left > 0) begin
				gap_left--;
				req.valid <= 1'b0;
			end else if (pending_q.size() > 0) begin
				r = pending_q.pop_front();
				req.kind  <= r.kind;
				req.index <= r.index;
				req.value <= r.value;
				req.valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 48);
					// A quarter of the bursts run straight into the next one.
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: drive ready at the falling edge from a pattern that is redrawn
	// whenever its randomly chosen run length is used up.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (rdy_left <= 0) begin
			rdy_mode = rdy_mode_t'($urandom_range(RDY_ALWAYS, RDY_PERIODIC));
			rdy_left = $urandom_range(32, 200);
		end
		rdy_left--;
		rdy_phase++;
		case (rdy_mode)
			RDY_ALWAYS:   rsp.ready <= 1'b1;
			RDY_MOSTLY:   rsp.ready <= ($urandom_range(0, 3) != 0);
			RDY_SPARSE:   rsp.ready <= ($urandom_range(0, 9) < 3);
			RDY_PERIODIC: rsp.ready <= rdy_phase[2];
			default:      rsp.ready <= 1'b1;
		endcase
	end

	// ------------------------------------------------------------------
	// Monitor: sample both channels at the rising edge. Predict on each
	// accepted request, check each accepted response against the oldest
	// prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		list_req_t r;
		list_rsp_t got;
		list_rsp_t exp;
		if (!arst_n) begin
			req_fired = 1'b0;
		end else begin
			req_fired = req.valid && req.ready;
			if (req_fired) begin
				r.kind  = req.kind;
				r.index = req.index;
				r.value = req.value;
				rsp_expect_q.push_back(apply_request(r));
				accepted_items++;
			end
			if (rsp.valid && rsp.ready) begin
				got.read_value = rsp.read_value;
				got.found      = rsp.found;
				got.count      = rsp.count;
				got.status     = rsp.status;
				if (rsp_expect_q.size() == 0) begin
					error_cnt++;
					if (error_cnt <= REPORT_MAX)
						$display("%0t: response transaction with nothing expected: %p",
							$realtime, got);
				end else begin
					exp = rsp_expect_q.pop_front();
					if (got.read_value !== exp.read_value || got.found !== exp.found ||
							got.count !== exp.count || got.status !== exp.status) begin
						error_cnt++;
						if (error_cnt <= REPORT_MAX)
							$display("%0t: mismatch read_value exp %h got %h, found exp %b got %b,",
								$realtime, exp.read_value, got.read_value,
								exp.found, got.found,
								" count exp %0d got %0d, status exp %0d got %0d",
								exp.count, got.count, exp.status, got.status);
					end
				end
			end
		end
	end

	// Watchdog: end the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("indexed_list_insert_remove_test: FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence: reset, build stimulus, wait for completion, report.
	// ------------------------------------------------------------------
	initial begin
		mix_t             mix;
		int               seg_left;
		int               useful;
		logic [KindW-1:0] k;

		arst_n    = 1'b0;
		req.valid = 1'b0;
		req.kind  = KIND_APPEND;
		req.index = '0;
		req.value = '0;
		rsp.ready = 1'b0;
		gen_count      = 0;
		accepted_items = 0;
		error_cnt      = 0;
		idle_cycles    = 0;
		req_fired      = 1'b0;
		burst_left     = $urandom_range(1, 48);
		gap_left       = 0;
		rdy_mode       = RDY_ALWAYS;
		rdy_left       = 0;
		rdy_phase      = 0;

		// Directed: empty-list errors, insert at and past the count,
		// value extremes, edge reads, finds, removes at both ends.
		queue_request(KIND_GET,    0, 32'sh0);
		queue_request(KIND_REMOVE, 0, 32'sh0);
		queue_request(KIND_FIND,   0, 32'sh0);
		queue_request(KIND_INSERT, 1, 32'sh1234_5678);
		queue_request(KIND_INSERT, 0, 32'sh7fff_ffff);  // at the count: acts as append
		queue_request(KIND_APPEND, 0, 32'sh8000_0000);
		queue_request(KIND_APPEND, 0, -32'sd1);
		queue_request(KIND_APPEND, 0, 32'sh0);
		queue_request(KIND_INSERT, 1, 32'sh5555_5555);
		queue_request(KIND_INSERT, 127, 32'shaaaa_aaaa);
		queue_request(KIND_GET,    0, 32'sh0);
		queue_request(KIND_GET,    4, 32'sh0);
		queue_request(KIND_GET,    5, 32'sh0);
		queue_request(KIND_GET,    127, 32'sh0);
		queue_request(KIND_FIND,   0, 32'sh8000_0000);
		queue_request(KIND_FIND,   0, -32'sd1);
		queue_request(KIND_FIND,   0, 32'sh1234_5678);
		queue_request(KIND_REMOVE, 4, 32'sh0);
		queue_request(KIND_REMOVE, 0, 32'sh0);
		queue_request(KIND_REMOVE, 3, 32'sh0);
		queue_request(KIND_REMOVE, 127, 32'sh0);
		for (int i = KIND_RSVD_FIRST; i <= KIND_RSVD_LAST; i++)
			queue_request(KindW'(i), 127, -32'sd1);

		// Random: segments that push the list to full, drain it, or keep it
		// in the middle, so full refusals and empty errors both recur.
		useful   = 0;
		seg_left = 0;
		mix      = MIX_GROW;
		while (useful < RANDOM_ITEMS) begin
			if (seg_left <= 0) begin
				mix      = mix_t'($urandom_range(MIX_GROW, MIX_BALANCED));
				seg_left = $urandom_range(40, 160);
			end
			seg_left--;
			k = pick_kind(mix);
			if (k >= KIND_RSVD_FIRST) begin
				queue_request(k, $urandom_range(0, (1 << IndexW) - 1), $urandom);
			end else begin
				queue_request(k, pick_index(k), pick_value());
				useful++;
			end
		end
		total_items = pending_q.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (accepted_items == total_items);
		while (rsp_expect_q.size() != 0)
			@(posedge clk);
		// Let any stray response show up before judging.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_cnt == 0)
			$display("indexed_list_insert_remove_test: PASS");
		else
			$display("indexed_list_insert_remove_test: FAIL");
		$finish;
	end

endmodule
`default_nettype wire
